>>> rtl/core/kcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Holds the mode encoding, the configuration and result bundles, register
// indexes and the keypad decoding helpers.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Number of digits collected before a code is checked.
    localparam int CODE_DIGITS = 4;

    localparam int CODE_W      = 14;
    localparam int COUNT_W     = 3;
    localparam int FAIL_W      = 2;
    localparam int TIMER_W     = 16;
    localparam int PHASE_W     = 4;
    localparam int BLINK_W     = 3;
    localparam int KEY_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // The displayed code keeps its last four decimal digits.
    localparam int CODE_MOD    = 10000;
    // Width of code * 10 + digit before the reduction.
    localparam int WIDE_W      = 17;

    localparam logic [KEY_W-1:0] KEY_HASH = KEY_W'(14);

    typedef enum logic [1:0] {
        MODE_ENTRY = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_LOCK  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PASSWORD     = 3'd0,
        REG_MAX_FAILURES = 3'd1,
        REG_LOCKOUT      = 3'd2,
        REG_BLINK_HALF   = 3'd3,
        REG_BLINK_COUNT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CODE_W-1:0]  password;
        logic [FAIL_W-1:0]  max_failures;
        logic [TIMER_W-1:0] lockout_ticks;
        logic [TIMER_W-1:0] blink_half_ticks;
        logic [BLINK_W-1:0] blink_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         lock_mode;
        logic               green_led;
        logic               red_led;
        logic               show_value;
        logic [CODE_W-1:0]  shown_value;
        logic [COUNT_W-1:0] digits_entered;
    } result_t;

    // True for the ten digit keys of the 4x4 keypad.
    function automatic logic key_is_digit(input logic [KEY_W-1:0] key);
        logic [15:0] digit_mask;
        digit_mask = 16'h2777;
        return digit_mask[key];
    endfunction

    // Decimal value printed on a keypad position; zero for non-digit keys.
    function automatic logic [3:0] key_digit(input logic [KEY_W-1:0] key);
        logic [3:0] d;
        unique case (key)
            4'd0:    d = 4'd1;
            4'd1:    d = 4'd2;
            4'd2:    d = 4'd3;
            4'd4:    d = 4'd4;
            4'd5:    d = 4'd5;
            4'd6:    d = 4'd6;
            4'd8:    d = 4'd7;
            4'd9:    d = 4'd8;
            4'd10:   d = 4'd9;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/core/keypad_code_lock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_top: keypad combination lock controller
// Takes key press and tick events and reports lock mode, LEDs and the code
// being entered after every event.
// ----------------------------------------------------------------------------
// An accepted request waits in the input register, and its result is written
// into the result register once that register is free; a held result waits
// there for the consumer.
// Throughput: one request per cycle while out_ready is high; the input and
// result registers each hold one request, so both sides can stall independently.
// Reset: rst_n clears the lock to entry mode with no digits, no failures and
// the configuration registers at their default values.
module keypad_code_lock_top
    import kcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [KEY_W-1:0]      key_position,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            lock_mode,
    output logic                  green_led,
    output logic                  red_led,
    output logic                  show_value,
    output logic [CODE_W-1:0]     shown_value,
    output logic [COUNT_W-1:0]    digits_entered
);

    cfg_t             cfg;
    result_t          result;
    result_t          res_reg;
    logic             res_valid_reg;
    logic             in_valid_reg;
    logic             func_reg;
    logic [KEY_W-1:0] key_reg;
    logic             res_free;
    logic             step;

    kcl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register can take a new result when it is empty or when its
    // current result leaves in this cycle. The held request is processed and
    // the lock state advances exactly when its result is written.
    assign res_free = !res_valid_reg || out_ready;
    assign step     = in_valid_reg && res_free;
    assign in_ready = !in_valid_reg || step;

    kcl_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .func         (func_reg),
        .key_position (key_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // Input register: holds one request until the core consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            key_reg  <= key_position;
        end
    end

    // Result register: holds one result until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = res_valid_reg;
    assign lock_mode      = res_reg.lock_mode;
    assign green_led      = res_reg.green_led;
    assign red_led        = res_reg.red_led;
    assign show_value     = res_reg.show_value;
    assign shown_value    = res_reg.shown_value;
    assign digits_entered = res_reg.digits_entered;

endmodule

>>> rtl/core/kcl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_cfg: configuration register file
// Five write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module kcl_cfg
    import kcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.password         <= CODE_W'(1234);
            cfg_reg.max_failures     <= FAIL_W'(3);
            cfg_reg.lockout_ticks    <= TIMER_W'(10000);
            cfg_reg.blink_half_ticks <= TIMER_W'(500);
            cfg_reg.blink_count      <= BLINK_W'(3);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PASSWORD:     cfg_reg.password         <= cfg_data[CODE_W-1:0];
                REG_MAX_FAILURES: cfg_reg.max_failures     <= cfg_data[FAIL_W-1:0];
                REG_LOCKOUT:      cfg_reg.lockout_ticks    <= cfg_data[TIMER_W-1:0];
                REG_BLINK_HALF:   cfg_reg.blink_half_ticks <= cfg_data[TIMER_W-1:0];
                REG_BLINK_COUNT:  cfg_reg.blink_count      <= cfg_data[BLINK_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/kcl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_core: lock state and next-state logic
// Holds mode, code entry, failure count and timers, and forms the result
// that describes the state after the current event.
// ----------------------------------------------------------------------------
module kcl_core
    import kcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             func,
    input  logic [KEY_W-1:0] key_position,
    input  cfg_t             cfg,
    output result_t          result
);

    mode_t               mode_reg, mode_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [FAIL_W-1:0]   fail_reg, fail_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;

    logic                is_key;
    logic [WIDE_W-1:0]   code_wide;
    logic [3:0]          quot;
    logic [WIDE_W-1:0]   code_rem;
    logic [CODE_W-1:0]   code_new;
    logic [COUNT_W:0]    count_inc;
    logic [FAIL_W-1:0]   fail_inc;
    logic                expired;
    logic [PHASE_W-1:0]  phase_inc;
    logic [PHASE_W-1:0]  phase_limit;

    assign is_key = !func;

    // code * 10 + digit, then reduced to four decimal digits. The quotient
    // is at most nine, so it is found by parallel compares.
    always_comb
    begin
        code_wide = (WIDE_W'(code_reg) << 3) + (WIDE_W'(code_reg) << 1)
                  + WIDE_W'(key_digit(key_position));
        quot = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (code_wide >= WIDE_W'(k * CODE_MOD))
            begin
                quot = 4'(k);
            end
        end
        code_rem = code_wide - WIDE_W'(quot) * WIDE_W'(CODE_MOD);
        code_new = code_rem[CODE_W-1:0];
    end

    assign count_inc   = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign fail_inc    = fail_reg + FAIL_W'(1);
    assign expired     = (timer_reg <= TIMER_W'(1));
    assign phase_inc   = phase_reg + PHASE_W'(1);
    assign phase_limit = {cfg.blink_count, 1'b0};

    always_comb
    begin
        mode_next  = mode_reg;
        code_next  = code_reg;
        count_next = count_reg;
        fail_next  = fail_reg;
        timer_next = timer_reg;
        phase_next = phase_reg;
        unique case (mode_reg)
            MODE_ENTRY:
            begin
                if (is_key && key_is_digit(key_position))
                begin
                    if (count_inc >= (COUNT_W+1)'(CODE_DIGITS))
                    begin
                        code_next  = '0;
                        count_next = '0;
                        if (code_new == cfg.password)
                        begin
                            mode_next = MODE_OPEN;
                        end
                        else if (fail_inc == '0 || fail_inc >= cfg.max_failures)
                        begin
                            fail_next  = '0;
                            mode_next  = MODE_LOCK;
                            timer_next = cfg.lockout_ticks;
                        end
                        else
                        begin
                            fail_next  = fail_inc;
                            mode_next  = MODE_BLINK;
                            phase_next = '0;
                            timer_next = cfg.blink_half_ticks;
                        end
                    end
                    else
                    begin
                        code_next  = code_new;
                        count_next = count_inc[COUNT_W-1:0];
                    end
                end
            end
            MODE_OPEN:
            begin
                if (is_key && key_position == KEY_HASH)
                begin
                    mode_next = MODE_ENTRY;
                end
            end
            MODE_BLINK:
            begin
                if (!is_key)
                begin
                    if (!expired)
                    begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                    else
                    begin
                        timer_next = '0;
                        if (phase_inc >= phase_limit)
                        begin
                            phase_next = '0;
                            mode_next  = MODE_ENTRY;
                        end
                        else
                        begin
                            phase_next = phase_inc;
                            timer_next = cfg.blink_half_ticks;
                        end
                    end
                end
            end
            MODE_LOCK:
            begin
                if (!is_key)
                begin
                    if (!expired)
                    begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                    else
                    begin
                        timer_next = '0;
                        mode_next  = MODE_ENTRY;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENTRY;
            code_reg  <= '0;
            count_reg <= '0;
            fail_reg  <= '0;
            timer_reg <= '0;
            phase_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            code_reg  <= code_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
            timer_reg <= timer_next;
            phase_reg <= phase_next;
        end
    end

    // The result shows the state after this event.
    always_comb
    begin
        result.lock_mode  = mode_next;
        result.green_led  = (mode_next == MODE_OPEN);
        result.red_led    = (mode_next == MODE_LOCK)
                         || (mode_next == MODE_BLINK && !phase_next[0]);
        if (mode_next == MODE_ENTRY)
        begin
            result.show_value     = (count_next != '0);
            result.shown_value    = code_next;
            result.digits_entered = count_next;
        end
        else
        begin
            result.show_value     = 1'b0;
            result.shown_value    = '0;
            result.digits_entered = '0;
        end
    end

endmodule

>>> tb/tb_keypad_code_lock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_code_lock_top: self-checking bench for the keypad code lock
// Drives key press and tick requests through the valid/ready input, predicts
// every result with a behavioral model of the lock, and compares each result
// field by field. Several lock settings are loaded, including the extremes
// of the password, the failure limit and the blink count and zero timers,
// and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock_top;

    import kcl_pkg::*;

    // The block passes a taken request through its input and result registers.
    localparam int LATENCY      = 1;
    // Receiver hold-off used to fill the block and stall its input.
    localparam int HOLD_CYCLES  = 300;
    // Hard stop for a hung run; far above the slowest correct run.
    localparam int RUN_LIMIT_NS = 8_000_000;

    // Keypad positions used by name (row * 4 + column).
    localparam logic [KEY_W-1:0] KEY_A    = KEY_W'(3);
    localparam logic [KEY_W-1:0] KEY_STAR = KEY_W'(12);
    localparam logic [KEY_W-1:0] KEY_ZERO = KEY_W'(13);
    localparam logic [KEY_W-1:0] KEY_D    = KEY_W'(15);

    // One keypad or tick request as the sender sees it.
    typedef struct packed {
        logic             is_tick;
        logic [KEY_W-1:0] key;
    } key_req_t;

    // ------------------------------------------------------------------------
    // Lock behavior and result checking. The lock's state and its settings
    // are kept here and advanced on every request the block accepts; the
    // results that follow are queued and matched in order.
    // ------------------------------------------------------------------------
    class lock_scoreboard;
        logic [CODE_W-1:0]  password;
        logic [FAIL_W-1:0]  max_failures;
        logic [TIMER_W-1:0] lockout_ticks;
        logic [TIMER_W-1:0] blink_half;
        logic [BLINK_W-1:0] blink_count;

        mode_t       mode;
        int unsigned code;
        int unsigned digits;
        int unsigned failures;
        int unsigned timer;
        int unsigned phase;

        result_t     expected_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned opens;
        int unsigned lockouts;

        function new();
            password      = CODE_W'(1234);
            max_failures  = FAIL_W'(3);
            lockout_ticks = TIMER_W'(10000);
            blink_half    = TIMER_W'(500);
            blink_count   = BLINK_W'(3);
            mode          = MODE_ENTRY;
            code          = 0;
            digits        = 0;
            failures      = 0;
            timer         = 0;
            phase         = 0;
            errors        = 0;
            checked       = 0;
            opens         = 0;
            lockouts      = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PASSWORD:     password      = value[CODE_W-1:0];
                REG_MAX_FAILURES: max_failures  = value[FAIL_W-1:0];
                REG_LOCKOUT:      lockout_ticks = value[TIMER_W-1:0];
                REG_BLINK_HALF:   blink_half    = value[TIMER_W-1:0];
                REG_BLINK_COUNT:  blink_count   = value[BLINK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Digit keys sit in the left three columns of the top three rows,
        // plus the zero key under the eight.
        function bit is_digit_key(logic [KEY_W-1:0] key);
            return (key == KEY_ZERO) || (key[1:0] != 2'd3 && key[3:2] != 2'd3);
        endfunction

        function int unsigned digit_of(logic [KEY_W-1:0] key);
            if (key == KEY_ZERO)
                return 0;
            return key[3:2] * 3 + key[1:0] + 1;
        endfunction

        // A timer of zero or one runs out on the next tick.
        function bit tick_runs_out();
            if (timer > 1) begin
                timer--;
                return 1'b0;
            end
            timer = 0;
            return 1'b1;
        endfunction

        function void judge_code();
            int unsigned entered;
            entered = code;
            code    = 0;
            digits  = 0;
            if (entered == password) begin
                mode = MODE_OPEN;
                opens++;
                return;
            end
            // The failure count is two bits wide and may wrap to zero; a
            // wrapped count and one at or past the limit both lock out.
            failures = (failures + 1) & 3;
            if (failures == 0 || failures >= max_failures) begin
                failures = 0;
                mode     = MODE_LOCK;
                timer    = lockout_ticks;
                lockouts++;
            end else begin
                mode  = MODE_BLINK;
                phase = 0;
                timer = blink_half;
            end
        endfunction

        function logic [161:0] state_sig();
            return {mode, code, digits, failures, timer, phase};
        endfunction

        // Advances the lock by one request and queues the result it causes.
        // Returns 1 when the request changed the lock's state.
        function bit note_request(logic is_tick, logic [KEY_W-1:0] key);
            logic [161:0] prior;
            result_t      r;
            prior = state_sig();
            case (mode)
                MODE_ENTRY:
                    if (!is_tick && is_digit_key(key)) begin
                        code = (code * 10 + digit_of(key)) % 10000;
                        if (digits + 1 >= CODE_DIGITS)
                            judge_code();
                        else
                            digits = (digits + 1) & 7;
                    end
                MODE_OPEN:
                    if (!is_tick && key == KEY_HASH)
                        mode = MODE_ENTRY;
                MODE_BLINK:
                    if (is_tick && tick_runs_out()) begin
                        phase = (phase + 1) & 15;
                        if (phase >= 2 * blink_count) begin
                            phase = 0;
                            mode  = MODE_ENTRY;
                        end else begin
                            timer = blink_half;
                        end
                    end
                default:
                    if (is_tick && tick_runs_out())
                        mode = MODE_ENTRY;
            endcase

            r = '0;
            r.lock_mode = mode;
            r.green_led = (mode == MODE_OPEN);
            r.red_led   = (mode == MODE_LOCK) || (mode == MODE_BLINK && (phase & 1) == 0);
            if (mode == MODE_ENTRY) begin
                r.show_value     = (digits != 0);
                r.shown_value    = CODE_W'(code);
                r.digits_entered = COUNT_W'(digits);
            end
            expected_q.push_back(r);
            return state_sig() != prior;
        endfunction

        function void compare_field(string label, logic [CODE_W-1:0] want,
                                    logic [CODE_W-1:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t ns: result with no request outstanding (lock_mode %0d)",
                         $time, got.lock_mode);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("lock_mode",      want.lock_mode,      got.lock_mode);
            compare_field("green_led",      want.green_led,      got.green_led);
            compare_field("red_led",        want.red_led,        got.red_led);
            compare_field("show_value",     want.show_value,     got.show_value);
            compare_field("shown_value",    want.shown_value,    got.shown_value);
            compare_field("digits_entered", want.digits_entered, got.digits_entered);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_PASSWORD;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  func         = 1'b0;
    logic [KEY_W-1:0]      key_position = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [1:0]            lock_mode;
    logic                  green_led;
    logic                  red_led;
    logic                  show_value;
    logic [CODE_W-1:0]     shown_value;
    logic [COUNT_W-1:0]    digits_entered;

    lock_scoreboard sb = new();

    // Requests still to be offered, built a few at a time.
    key_req_t    plan_q[$];
    // When set, neither side idles; used for fast stretches.
    bit          quiet        = 1'b0;
    // When set, the entry side never plans the password as a full code.
    bit          force_wrong  = 1'b0;
    // Long receiver hold-offs asked for by the sender, and those done.
    int unsigned hold_ask     = 0;
    int unsigned holds_served = 0;
    int unsigned phase_effect = 0;
    int unsigned requests     = 0;
    int unsigned settings_run = 0;

    keypad_code_lock_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .key_position   (key_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lock_mode      (lock_mode),
        .green_led      (green_led),
        .red_led        (red_led),
        .show_value     (show_value),
        .shown_value    (shown_value),
        .digits_entered (digits_entered)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length for either side: mostly none, often a few cycles, and now
    // and then a long gap.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Request building.
    // ------------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] key_for_digit(int unsigned d);
        if (d == 0)
            return KEY_ZERO;
        return KEY_W'(((d - 1) / 3) * 4 + (d - 1) % 3);
    endfunction

    function automatic void queue_key(logic [KEY_W-1:0] k);
        plan_q.push_back('{1'b0, k});
    endfunction

    // Ticks carry a random key position, which the block must disregard.
    function automatic void queue_tick();
        plan_q.push_back('{1'b1, KEY_W'($urandom_range(0, 15))});
    endfunction

    function automatic void queue_noise();
        plan_q.push_back('{1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 15))});
    endfunction

    function automatic void queue_code(int unsigned c);
        queue_key(key_for_digit((c / 1000) % 10));
        queue_key(key_for_digit((c / 100) % 10));
        queue_key(key_for_digit((c / 10) % 10));
        queue_key(key_for_digit(c % 10));
    endfunction

    // Picks the next few requests from the lock's predicted mode, so that most
    // traffic follows a real user: digits up to a full code in entry, the close
    // key when open, and ticks in blink and lockout. A share of it is noise.
    function automatic void make_plan();
        int r;
        r = $urandom_range(0, 99);
        case (sb.mode)
            MODE_ENTRY:
                if (sb.digits == 0 && r < 40 && !force_wrong && sb.password <= 14'd9999)
                    queue_code(sb.password);
                else if (r < 85)
                    repeat (CODE_DIGITS - sb.digits)
                        queue_key(key_for_digit($urandom_range(0, 9)));
                else
                    repeat ($urandom_range(1, 3))
                        queue_noise();
            MODE_OPEN:
                if (r < 30)
                    queue_noise();
                else
                    queue_key(KEY_HASH);
            default:
                if (r < 8)
                    queue_key(KEY_W'($urandom_range(0, 15)));
                else
                    queue_tick();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. Inputs change only by nonblocking assignment just after
    // a rising edge, and valid is never dropped and raised in one step.
    // ------------------------------------------------------------------------

    // Offers one request after an optional gap and returns at the edge that
    // accepts it; the prediction is advanced at that same edge.
    task automatic send_request(input logic is_tick, input logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= is_tick;
        key_position <= key;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        phase_effect += sb.note_request(is_tick, key);
        requests++;
    endtask

    task automatic play_queue();
        key_req_t item;
        while (plan_q.size() != 0) begin
            item = plan_q.pop_front();
            send_request(item.is_tick, item.key);
        end
    endtask

    // Stops offering and waits until every expected result has come back,
    // then lets the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Writes all five registers, one per cycle; only called while idle.
    task automatic load_settings(input int unsigned pw, input int unsigned mf,
                                 input int unsigned lo, input int unsigned bh,
                                 input int unsigned bc);
        cfg_index_t            order[5];
        logic [CFG_DATA_W-1:0] setting[5];
        order   = '{REG_PASSWORD, REG_MAX_FAILURES, REG_LOCKOUT, REG_BLINK_HALF,
                    REG_BLINK_COUNT};
        setting = '{CFG_DATA_W'(pw), CFG_DATA_W'(mf), CFG_DATA_W'(lo), CFG_DATA_W'(bh),
                    CFG_DATA_W'(bc)};
        for (int i = 0; i < 5; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= setting[i];
            @(posedge clk);
            sb.set_reg(order[i], setting[i]);
        end
        cfg_write <= 1'b0;
    endtask

    // One random stretch under one lock setting. It runs until enough
    // requests have changed the lock's state, and then on until any red
    // phase is over, so a long lockout or blink is always seen to its end.
    // With squeeze set, the receiver is held off for a long stretch while
    // requests keep coming, and later the sender waits for a full drain.
    task automatic run_phase(input int unsigned pw, input int unsigned mf,
                             input int unsigned lo, input int unsigned bh,
                             input int unsigned bc, input int unsigned target,
                             input bit calm, input bit fail_only, input bit squeeze);
        bit       held;
        bit       paused;
        key_req_t item;
        held   = 1'b0;
        paused = 1'b0;
        load_settings(pw, mf, lo, bh, bc);
        quiet        = calm;
        force_wrong  = fail_only;
        phase_effect = 0;
        plan_q.delete();
        while (phase_effect < target || sb.mode == MODE_BLINK || sb.mode == MODE_LOCK) begin
            if (plan_q.size() == 0)
                make_plan();
            item = plan_q.pop_front();
            send_request(item.is_tick, item.key);
            if (squeeze && !held && phase_effect >= 20) begin
                held = 1'b1;
                hold_ask++;
            end
            if (squeeze && !paused && phase_effect >= 50) begin
                paused = 1'b1;
                wait_idle();
            end
        end
        // A half-typed code may be left behind; the lock keeps it and so
        // does the prediction.
        plan_q.delete();
        wait_idle();
        quiet       = 1'b0;
        force_wrong = 1'b0;
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: takes results when ready is high and checks each one.
    // Ready drops at random, and for a long hold-off when the sender asks.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        result_t seen;
        int      stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                seen.lock_mode      = lock_mode;
                seen.green_led      = green_led;
                seen.red_led        = red_led;
                seen.show_value     = show_value;
                seen.shown_value    = shown_value;
                seen.digits_entered = digits_entered;
                sb.check_result(seen);
            end
            if (holds_served != hold_ask) begin
                holds_served++;
                stall_left = 0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the settings the lock comes out of reset with.
        // Letter keys and ticks do nothing in entry; the default code opens
        // the lock; keys other than the close key and ticks do nothing while
        // open; the close key returns to entry.
        queue_key(KEY_A);
        queue_key(KEY_D);
        queue_tick();
        queue_code(1234);
        queue_key(key_for_digit(5));
        queue_tick();
        queue_key(KEY_HASH);
        play_queue();
        wait_idle();

        // Short timers and a limit of two failures. The digit code 0065 is
        // just a wrong code and starts a single blink; a key during the blink
        // is ignored. A second wrong code reaches the limit and locks out,
        // and the close key is ignored during the lockout.
        load_settings(9999, 2, 3, 2, 1);
        queue_code(65);
        queue_key(KEY_STAR);
        repeat (4) queue_tick();
        queue_code(1111);
        queue_key(KEY_HASH);
        repeat (3) queue_tick();
        play_queue();
        wait_idle();

        // Random part, one stretch per setting.
        // All-zero password, and a limit of zero so every failure locks out.
        run_phase(0, 0, 1, 1, 0, 50, 1'b0, 1'b0, 1'b0);
        // Longest blink sequence with the highest failure limit.
        run_phase($urandom_range(0, 9999), 3, 4, 2, 7, 70, 1'b0, 1'b0, 1'b0);
        // Password past 9999 that can never match, with zero timers that act
        // as one tick; no idling on either side here.
        run_phase(16383, 2, 0, 0, 2, 60, 1'b1, 1'b0, 1'b0);
        // A lockout of forty ticks, every failure locking out.
        run_phase($urandom_range(0, 9999), 1, 40, 3, 3, 40, 1'b1, 1'b1, 1'b0);
        // A longer blink half period with a blink count of zero, so the blink
        // ends after its first red half.
        run_phase($urandom_range(0, 9999), 2, 2, 30, 0, 40, 1'b1, 1'b1, 1'b0);
        // Back-pressure: long receiver hold-off, then a full drain mid-way.
        run_phase($urandom_range(0, 9999), 3, 5, 1, 1, 80, 1'b0, 1'b0, 1'b1);
        // Password just above the four-digit range.
        run_phase(10000, 3, 2, 2, 4, 70, 1'b0, 1'b0, 1'b0);
        // Default password again.
        run_phase(1234, 3, 6, 3, 3, 70, 1'b0, 1'b0, 1'b0);

        wait_idle();
        repeat (4 * LATENCY) @(posedge clk);

        $display("Covered %0d requests over %0d lock settings plus the directed part:",
                 requests, settings_run);
        $display("%0d results checked, %0d openings, %0d lockouts, %0d errors.",
                 sb.checked, sb.opens, sb.lockouts, sb.errors);
        if (sb.errors == 0)
            $display("keypad_code_lock_top verification clean");
        else
            $display("keypad_code_lock_top verification failed");
        $finish;
    end

    // Guard against a hang anywhere in the run.
    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d results outstanding.", sb.pending());
        $display("keypad_code_lock_top verification failed");
        $finish;
    end

endmodule
